FILE: sv/scs_pkg.sv
// Package for the source comment stripper: queue entry and status types,
// character and error code constants. No dependencies.

package scs_pkg;

   localparam int QueueDepth = 4;
   localparam int PtrBits    = $clog2(QueueDepth);
   localparam int CountBits  = $clog2(QueueDepth + 1);

   localparam logic [7:0] CharSlash = 8'h2f;
   localparam logic [7:0] CharStar  = 8'h2a;
   localparam logic [7:0] CharNl    = 8'h0a;
   localparam logic [7:0] CharSpace = 8'h20;
   localparam logic [7:0] CharSq    = 8'h27;
   localparam logic [7:0] CharDq    = 8'h22;
   localparam logic [7:0] CharNul   = 8'h00;

   localparam logic [1:0] ErrNone       = 2'd0;
   localparam logic [1:0] ErrOpenBlock  = 2'd1;
   localparam logic [1:0] ErrStrayClose = 2'd2;

   // one accepted byte's worth of results: an optional held symbol, then the final item
   typedef struct packed {
      logic        two;
      logic [7:0]  c0;
      logic [7:0]  c1;
      logic        end_f;
      logic [1:0]  err;
      logic [15:0] line;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

FILE: sv/source_comment_stripper_top.sv
// Top level of the source comment stripper: front, entry queue and back.
// Depends on scs_pkg, scs_front, scs_queue, scs_back.
//
//   port group | dir | payload
//   req_*      | in  | tdata: char_in; tuser: end_in
//   rsp_*      | out | tdata: char_out, line_out; tuser: end_out, error_code; tlast: last
//
// One byte is accepted per cycle while the four-entry queue has room.
// Each byte gives zero, one or two items; the back emits one item per cycle
// while rsp_tready allows, so a byte giving two items presents them in turn.
// An accepted byte's items pass through the queue and then the output register.
// Reset is synchronous and clears mode, held symbol, queue and output valid flag.
// After an error or end item, bytes are taken and dropped until reset.

module source_comment_stripper_top import scs_pkg::*; #(
   parameter int LINE_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // char_in
   input  logic        req_tuser,   // end_in
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // char_out [7:0], line_out [23:8]
   output logic [2:0]  rsp_tuser,   // end_out [0], error_code [2:1]
   output logic        rsp_tlast
);

   queue_status_type q_status;
   entry_type        push_entry;
   entry_type        head;
   logic             push, pop;

   scs_front #(
      .LINE_BITS(LINE_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_status   (q_status),
      .push       (push),
      .entry      (push_entry)
   );

   scs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (q_status)
   );

   scs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .q_status   (q_status),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_status.full)
      else $error("push into full queue");

   a_quiet_after_final: assert property (@(posedge clock) disable iff (reset)
      push && (push_entry.end_f || push_entry.err != ErrNone) |=> !push)
      else $error("entry pushed after end or error");

   a_final_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != 3'd0) |-> rsp_tlast)
      else $error("end or error item not marked last");

   a_line_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[23:8] != 16'd0))
      else $error("line number zero");

endmodule

FILE: sv/scs_front.sv
// Front part of the comment stripper: accepts bytes, tracks lexical mode and line count,
// and pushes result entries into the queue. Depends on scs_pkg.

module scs_front import scs_pkg::*; #(
   parameter int LINE_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [7:0]       req_tdata,   // char_in
   input  logic             req_tuser,   // end_in
   input  queue_status_type q_status,
   output logic             push,
   output entry_type        entry
);

   localparam logic [2:0] ModeNormal = 3'd0;
   localparam logic [2:0] ModeQuote  = 3'd1;
   localparam logic [2:0] ModeLine   = 3'd2;
   localparam logic [2:0] ModeBlock  = 3'd3;
   localparam logic [2:0] ModeError  = 3'd4;
   localparam logic [2:0] ModeEnded  = 3'd5;

   localparam logic [1:0] HeldNone  = 2'd0;
   localparam logic [1:0] HeldSlash = 2'd1;
   localparam logic [1:0] HeldStar  = 2'd2;

   localparam int ExtBits = (LINE_BITS > 16) ? LINE_BITS : 16;

   logic [2:0]           mode_ff, mode_in;
   logic [7:0]           quote_ff, quote_in;
   logic [1:0]           held_ff, held_in;
   logic                 star_ff, star_in;
   logic [LINE_BITS-1:0] line_ff, line_in;

   logic                 accept;
   logic [7:0]           c;
   logic [7:0]           held_char;
   logic                 emit_held, emit_main, do_fresh;
   logic [7:0]           main_c;
   logic                 end_f;
   logic [1:0]           err;
   logic                 nl_block, nl_out, inc;
   logic [ExtBits-1:0]   line_ext;
   logic [15:0]          line_sat;

   assign req_tready = !q_status.full;
   assign accept     = req_tvalid && req_tready;
   assign c          = req_tdata;
   assign held_char  = (held_ff == HeldSlash) ? CharSlash : CharStar;

   always_comb begin
      mode_in   = mode_ff;
      quote_in  = quote_ff;
      held_in   = held_ff;
      star_in   = star_ff;
      emit_held = 1'b0;
      emit_main = 1'b0;
      do_fresh  = 1'b0;
      main_c    = c;
      end_f     = 1'b0;
      err       = ErrNone;
      nl_block  = 1'b0;
      if (mode_ff == ModeError || mode_ff == ModeEnded) begin
         main_c = CharNul;
      end else if (req_tuser) begin
         main_c    = CharNul;
         emit_main = 1'b1;
         if (mode_ff == ModeBlock) begin
            err     = ErrOpenBlock;
            mode_in = ModeError;
         end else begin
            emit_held = (mode_ff == ModeNormal) && (held_ff != HeldNone);
            held_in   = HeldNone;
            end_f     = 1'b1;
            mode_in   = ModeEnded;
         end
      end else begin
         unique case (mode_ff)
            ModeNormal: begin
               if (held_ff == HeldSlash) begin
                  held_in = HeldNone;
                  if (c == CharSlash) begin
                     mode_in = ModeLine;
                  end else if (c == CharStar) begin
                     mode_in = ModeBlock;
                     star_in = 1'b0;
                  end else begin
                     emit_held = 1'b1;
                     do_fresh  = 1'b1;
                  end
               end else if (held_ff == HeldStar) begin
                  held_in = HeldNone;
                  if (c == CharSlash) begin
                     emit_main = 1'b1;
                     main_c    = CharNul;
                     err       = ErrStrayClose;
                     mode_in   = ModeError;
                  end else begin
                     emit_held = 1'b1;
                     do_fresh  = 1'b1;
                  end
               end else begin
                  do_fresh = 1'b1;
               end
            end
            ModeQuote: begin
               emit_main = 1'b1;
               if (c == quote_ff || c == CharNl) begin
                  mode_in = ModeNormal;
               end
            end
            ModeLine: begin
               if (c == CharNl) begin
                  emit_main = 1'b1;
                  mode_in   = ModeNormal;
               end
            end
            ModeBlock: begin
               nl_block = (c == CharNl);
               if (star_ff && c == CharSlash) begin
                  emit_main = 1'b1;
                  main_c    = CharSpace;
                  mode_in   = ModeNormal;
                  star_in   = 1'b0;
               end else begin
                  star_in = (c == CharStar);
               end
            end
            default: begin
            end
         endcase
         if (do_fresh) begin
            if (c == CharSlash) begin
               held_in = HeldSlash;
            end else if (c == CharStar) begin
               held_in = HeldStar;
            end else begin
               emit_main = 1'b1;
               if (c == CharSq || c == CharDq) begin
                  mode_in  = ModeQuote;
                  quote_in = c;
               end
            end
         end
      end
   end

   assign line_ext = ExtBits'(line_ff);
   assign line_sat = (line_ext > ExtBits'(16'hffff)) ? 16'hffff : line_ext[15:0];

   assign nl_out  = emit_main && !end_f && (err == ErrNone) && (main_c == CharNl);
   assign inc     = nl_out || nl_block;
   assign line_in = (inc && (line_ff != {LINE_BITS{1'b1}})) ? line_ff + 1'b1 : line_ff;

   assign push        = accept && (emit_held || emit_main);
   assign entry.two   = emit_held && emit_main;
   assign entry.c0    = held_char;
   assign entry.c1    = emit_main ? main_c : held_char;
   assign entry.end_f = emit_main && end_f;
   assign entry.err   = emit_main ? err : ErrNone;
   assign entry.line  = line_sat;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= ModeNormal;
         quote_ff <= CharNul;
         held_ff  <= HeldNone;
         star_ff  <= 1'b0;
         line_ff  <= LINE_BITS'(1);
      end else if (accept) begin
         mode_ff  <= mode_in;
         quote_ff <= quote_in;
         held_ff  <= held_in;
         star_ff  <= star_in;
         line_ff  <= line_in;
      end
   end

endmodule

FILE: sv/scs_queue.sv
// Short entry queue between the front and back parts of the comment stripper.
// Depends on scs_pkg.

module scs_queue import scs_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  entry_type        push_entry,
   input  logic             pop,
   output entry_type        head,
   output queue_status_type status
);

   entry_type             slot_ff [QueueDepth];
   logic [PtrBits-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [CountBits-1:0]  count_ff, count_in;

   assign status.full  = (count_ff == CountBits'(QueueDepth));
   assign status.empty = (count_ff == '0);
   assign head         = slot_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

endmodule

FILE: sv/scs_back.sv
// Back part of the comment stripper: expands queue entries into result items
// and holds them in the output register. Depends on scs_pkg.

module scs_back import scs_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  entry_type        head,
   input  queue_status_type q_status,
   output logic             pop,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [23:0]      rsp_tdata,   // char_out [7:0], line_out [23:8]
   output logic [2:0]       rsp_tuser,   // end_out [0], error_code [2:1]
   output logic             rsp_tlast
);

   logic        valid_ff, valid_in;
   logic        phase_ff, phase_in;
   logic [23:0] data_ff;
   logic [2:0]  user_ff;
   logic        last_ff;
   logic        load, first;

   assign load  = !q_status.empty && (!valid_ff || rsp_tready);
   assign first = head.two && !phase_ff;
   assign pop   = load && !first;

   always_comb begin
      valid_in = valid_ff;
      phase_in = phase_ff;
      if (load) begin
         valid_in = 1'b1;
         phase_in = first;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= {head.line, first ? head.c0 : head.c1};
         user_ff <= first ? {ErrNone, 1'b0} : {head.err, head.end_f};
         last_ff <= !first;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = user_ff;
   assign rsp_tlast  = last_ff;

endmodule

FILE: tb/sv/tb.sv
// Testbench for source_comment_stripper_top: drives a byte stream with bursts and gaps,
// predicts the stripped characters, line numbers and error codes, and checks every item.
// Depends on scs_pkg and source_comment_stripper_top.
`timescale 1ns / 100ps

module tb import scs_pkg::*;;

   localparam int          CycleLimit   = 400_000;
   localparam int          RandomTarget = 520;
   localparam logic [15:0] LineMax      = 16'hffff;

   typedef enum logic [2:0] {
      ScanText, ScanQuote, ScanLine, ScanBlock, ScanError, ScanEnded
   } scan_mode_type;

   typedef enum logic [1:0] {HeldNone, HeldSlash, HeldStar} held_sym_type;

   typedef struct packed {
      logic [7:0]  ch;
      logic        fin;
      logic [15:0] line;
      logic [1:0]  err;
      logic        last;
   } strip_item_type;

   typedef struct packed {
      logic [7:0]  ch;
      logic        typed;
      logic [1:0]  count;
      logic [7:0]  first;
      logic [7:0]  second;
      logic [15:0] line;
   } opening_row_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // char_in
   logic        req_tuser = 1'b0;    // end_in
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;           // char_out [7:0], line_out [23:8]
   logic [2:0]  rsp_tuser;           // end_out [0], error_code [2:1]
   logic        rsp_tlast;

   scan_mode_type  scan_mode = ScanText;
   held_sym_type   held_sym = HeldNone;
   logic [7:0]     quote_ch = 8'h00;
   logic           star_pending = 1'b0;
   logic [15:0]    line_no = 16'd1;
   logic           nl_pending = 1'b0;

   strip_item_type step_items[$];
   strip_item_type awaited_chars[$];
   strip_item_type want_item;

   int  fail_count = 0;
   int  cycle_count = 0;
   int  bytes_sent = 0;
   int  burst_left = 0;
   int  stall_left = 0;
   int  stall_style = 0;
   bit  stray_ok = 1'b0;

   opening_row_type opening_rows [25] = '{
      '{"a",       1'b1, 2'd1, "a",       CharNul, 16'd1},
      '{8'h00,     1'b1, 2'd1, 8'h00,     CharNul, 16'd1},
      '{8'hff,     1'b1, 2'd1, 8'hff,     CharNul, 16'd1},
      '{CharSlash, 1'b1, 2'd0, CharNul,   CharNul, 16'd1},
      '{"x",       1'b1, 2'd2, CharSlash, "x",     16'd1},
      '{CharStar,  1'b1, 2'd0, CharNul,   CharNul, 16'd1},
      '{CharStar,  1'b1, 2'd1, CharStar,  CharNul, 16'd1},
      '{"q",       1'b1, 2'd2, CharStar,  "q",     16'd1},
      '{CharDq,    1'b1, 2'd1, CharDq,    CharNul, 16'd1},
      '{CharSlash, 1'b1, 2'd1, CharSlash, CharNul, 16'd1},
      '{CharStar,  1'b1, 2'd1, CharStar,  CharNul, 16'd1},
      '{CharSq,    1'b1, 2'd1, CharSq,    CharNul, 16'd1},
      '{CharDq,    1'b1, 2'd1, CharDq,    CharNul, 16'd1},
      '{CharSq,    1'b1, 2'd1, CharSq,    CharNul, 16'd1},
      '{CharNl,    1'b1, 2'd1, CharNl,    CharNul, 16'd1},
      '{CharSlash, 1'b0, 2'd0, CharNul,   CharNul, 16'd0},
      '{CharSlash, 1'b0, 2'd0, CharNul,   CharNul, 16'd0},
      '{"z",       1'b0, 2'd0, CharNul,   CharNul, 16'd0},
      '{CharNl,    1'b0, 2'd0, CharNul,   CharNul, 16'd0},
      '{CharSlash, 1'b0, 2'd0, CharNul,   CharNul, 16'd0},
      '{CharStar,  1'b0, 2'd0, CharNul,   CharNul, 16'd0},
      '{CharSlash, 1'b0, 2'd0, CharNul,   CharNul, 16'd0},
      '{CharNl,    1'b0, 2'd0, CharNul,   CharNul, 16'd0},
      '{CharStar,  1'b0, 2'd0, CharNul,   CharNul, 16'd0},
      '{CharSlash, 1'b0, 2'd0, CharNul,   CharNul, 16'd0}
   };

   source_comment_stripper_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic void advance_line();
      if (line_no != LineMax) line_no = line_no + 16'd1;
   endfunction

   function automatic void emit_char(logic [7:0] ch, logic fin, logic [1:0] err);
      step_items.push_back('{ch, fin, line_no, err, 1'b0});
      if (!fin && err == ErrNone && ch == CharNl) nl_pending = 1'b1;
   endfunction

   function automatic void take_fresh(logic [7:0] c);
      if (c == CharSlash) begin
         held_sym = HeldSlash;
      end else if (c == CharStar) begin
         held_sym = HeldStar;
      end else begin
         if (c == CharSq || c == CharDq) begin
            scan_mode = ScanQuote;
            quote_ch = c;
         end
         emit_char(c, 1'b0, ErrNone);
      end
   endfunction

   function automatic void strip_byte(logic [7:0] c, logic fin);
      step_items.delete();
      if (scan_mode == ScanError || scan_mode == ScanEnded) return;
      if (nl_pending) begin
         advance_line();
         nl_pending = 1'b0;
      end
      if (fin) begin
         if (scan_mode == ScanBlock) begin
            emit_char(CharNul, 1'b0, ErrOpenBlock);
            scan_mode = ScanError;
         end else begin
            if (scan_mode == ScanText && held_sym != HeldNone)
               emit_char(held_sym == HeldSlash ? CharSlash : CharStar, 1'b0, ErrNone);
            held_sym = HeldNone;
            emit_char(CharNul, 1'b1, ErrNone);
            scan_mode = ScanEnded;
         end
      end else begin
         case (scan_mode)
            ScanText: begin
               if (held_sym == HeldSlash) begin
                  held_sym = HeldNone;
                  if (c == CharSlash) begin
                     scan_mode = ScanLine;
                  end else if (c == CharStar) begin
                     scan_mode = ScanBlock;
                     star_pending = 1'b0;
                  end else begin
                     emit_char(CharSlash, 1'b0, ErrNone);
                     take_fresh(c);
                  end
               end else if (held_sym == HeldStar) begin
                  held_sym = HeldNone;
                  if (c == CharSlash) begin
                     emit_char(CharNul, 1'b0, ErrStrayClose);
                     scan_mode = ScanError;
                  end else begin
                     emit_char(CharStar, 1'b0, ErrNone);
                     take_fresh(c);
                  end
               end else begin
                  take_fresh(c);
               end
            end
            ScanQuote: begin
               emit_char(c, 1'b0, ErrNone);
               if (c == quote_ch || c == CharNl) scan_mode = ScanText;
            end
            ScanLine: begin
               if (c == CharNl) begin
                  emit_char(c, 1'b0, ErrNone);
                  scan_mode = ScanText;
               end
            end
            default: begin
               if (c == CharNl) advance_line();
               if (star_pending && c == CharSlash) begin
                  emit_char(CharSpace, 1'b0, ErrNone);
                  scan_mode = ScanText;
                  star_pending = 1'b0;
               end else begin
                  star_pending = (c == CharStar);
               end
            end
         endcase
      end
      if (step_items.size() > 0) step_items[step_items.size() - 1].last = 1'b1;
   endfunction

   function automatic logic [7:0] printable();
      return 8'($urandom_range(8'h20, 8'h7e));
   endfunction

   function automatic logic [7:0] comment_char();
      case ($urandom_range(0, 5))
         0: return CharStar;
         1: return CharSlash;
         2: return CharNl;
         default: return printable();
      endcase
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      if (fail_count < 40)
         $display("%0t: %s mismatch: got %0h, want %0h", $realtime, what, got, want);
      fail_count++;
   endtask

   task automatic send_byte(input logic [7:0] c, input logic fin = 1'b0, input bit keep = 1'b1);
      int         gap;
      logic [7:0] byte_out;
      byte_out = c;
      if (!fin && !stray_ok && scan_mode == ScanText && held_sym == HeldStar
          && byte_out == CharSlash)
         byte_out = ".";
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if ($urandom_range(0, 3) != 0) begin
            gap = $urandom_range(1, 6);
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      if (burst_left > 0) burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= byte_out;
      req_tuser  <= fin;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
      strip_byte(byte_out, fin);
      if (keep) foreach (step_items[i]) awaited_chars.push_back(step_items[i]);
   endtask

   // leave the stripper in plain text with nothing held
   task automatic settle_text();
      if (scan_mode == ScanBlock) begin
         send_byte(CharStar);
         send_byte(CharSlash);
      end
      send_byte(CharNl);
   endtask

   task automatic send_segment();
      int         len;
      logic [7:0] q;
      len = $urandom_range(0, 8);
      case ($urandom_range(0, 9))
         0, 1, 2: repeat (len + 1) send_byte(printable());
         3: send_byte(8'($urandom_range(0, 255)));
         4: send_byte(CharNl);
         5: begin
            q = $urandom_range(0, 1) ? CharDq : CharSq;
            send_byte(q);
            repeat (len) send_byte(comment_char());
            send_byte(($urandom_range(0, 3) == 0) ? CharNl : q);
         end
         6: begin
            send_byte(CharSlash);
            send_byte(CharSlash);
            repeat (len) send_byte(comment_char());
            send_byte(CharNl);
         end
         7: begin
            send_byte(CharSlash);
            send_byte(CharStar);
            repeat (len) send_byte(comment_char());
            send_byte(CharStar);
            send_byte(CharSlash);
         end
         8: begin
            send_byte($urandom_range(0, 1) ? CharSlash : CharStar);
            send_byte(comment_char());
         end
         default: begin
            case ($urandom_range(0, 4))
               0: send_byte(CharSlash);
               1: send_byte(CharStar);
               2: send_byte(CharSq);
               3: send_byte(CharDq);
               default: send_byte(CharNl);
            endcase
         end
      endcase
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (awaited_chars.size() == 0) begin
            report_mismatch("unexpected item", rsp_tdata, 0);
         end else begin
            want_item = awaited_chars.pop_front();
            if (rsp_tdata[7:0] != want_item.ch)
               report_mismatch("char_out", rsp_tdata[7:0], want_item.ch);
            if (rsp_tdata[23:8] != want_item.line)
               report_mismatch("line_out", rsp_tdata[23:8], want_item.line);
            if (rsp_tuser[0] != want_item.fin)
               report_mismatch("end_out", rsp_tuser[0], want_item.fin);
            if (rsp_tuser[2:1] != want_item.err)
               report_mismatch("error_code", rsp_tuser[2:1], want_item.err);
            if (rsp_tlast != want_item.last)
               report_mismatch("last", rsp_tlast, want_item.last);
         end
      end
      if (stall_left == 0) begin
         stall_style = $urandom_range(0, 2);
         stall_left = $urandom_range(10, 150);
      end
      stall_left--;
      case (stall_style)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= 1'($urandom_range(0, 1));
         default: rsp_tready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CycleLimit) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      opening_row_type row;
      int              tail_goal;
      int              kind;
      int              drain;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (opening_rows[i]) begin
         row = opening_rows[i];
         send_byte(row.ch, 1'b0, !row.typed);
         if (row.typed)
            for (int k = 0; k < int'(row.count); k++)
               awaited_chars.push_back('{k == 0 ? row.first : row.second, 1'b0, row.line,
                                         ErrNone, k == int'(row.count) - 1});
      end

      while (bytes_sent < RandomTarget) send_segment();

      tail_goal = bytes_sent + 30;
      while (bytes_sent < tail_goal) send_segment();

      settle_text();
      kind = $urandom_range(0, 6);
      case (kind)
         1: send_byte(CharSlash);
         2: send_byte(CharStar);
         3: begin
            send_byte(CharSlash);
            send_byte(CharStar);
            send_byte(printable());
         end
         4: begin
            send_byte(CharStar);
            stray_ok = 1'b1;
            send_byte(CharSlash);
         end
         5: begin
            send_byte(CharDq);
            send_byte(printable());
         end
         6: begin
            send_byte(CharSlash);
            send_byte(CharSlash);
            send_byte(printable());
         end
         default: ;
      endcase
      if (kind != 4) send_byte(8'($urandom_range(0, 255)), 1'b1);
      repeat (6) send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      req_tvalid <= 1'b0;

      for (drain = 0; drain < 20000 && awaited_chars.size() != 0; drain++)
         @(posedge clock);
      repeat (16) @(posedge clock);
      if (awaited_chars.size() != 0)
         report_mismatch("items never emitted", awaited_chars.size(), 0);

      if (fail_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
